>>> rtl/vsgr_pkg.sv
// Shared constants, types and helper functions of the voxel set grid replicator.
package vsgr_pkg;

  localparam int SRC_DEPTH  = 64;
  localparam int COORD_BITS = 16;
  localparam int CELL_W     = 16;
  localparam int OUT_W      = 32;
  localparam int CNT_BITS   = 5;
  localparam int CI_W       = 3 * CNT_BITS;
  localparam int REL_W      = 14;
  localparam int ADD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ADDR_W     = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
  localparam int CNT_W      = $clog2(SRC_DEPTH + 1);
  localparam int MEM_W      = 3 * COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_COPY_COUNTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_STEP_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REL_STEP_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REL_STEP_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_STEP_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_STEP_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_STEP_Z  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_EN   = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [CI_W-1:0] COUNTS_RESET = 15'd1057;
  localparam logic [REL_W-1:0] REL_RESET   = 14'd256;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [REL_W-1:0]      rel_t;
  typedef logic signed [ADD_W-1:0]      add_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef struct packed {
    logic [CI_W-1:0] counts;
    rel_t [2:0]      rel;
    add_t [2:0]      add;
    logic            center;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [CI_W-1:0] ci;
    logic            idx_ok;
    cnt_t [2:0]      idx;
  } ofs_req_t;

  typedef struct packed {
    logic                  done;
    logic                  last;
    logic [CI_W-1:0]       ci;
    cnt_t [2:0]            idx;
    logic [2:0][OUT_W-1:0] off;
  } ofs_rsp_t;

  // A copy count of zero behaves as one.
  function automatic cnt_t clamp_cnt(input cnt_t n);
    return (n == '0) ? cnt_t'(1) : n;
  endfunction

  // The cell port pattern is taken as unsigned, and its low COORD_BITS bits
  // are read as a two's complement coordinate.
  function automatic coord_t to_coord(input logic [CELL_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return coord_t'(w[COORD_BITS-1:0]);
  endfunction

endpackage

>>> rtl/voxel_set_grid_replicator_unit.sv
// Top level of the voxel set grid replicator: source store, copy sequencing, result stream.
// A load request is taken while idle, and an emit request on an empty set leaves the block idle.
// An emit request over N stored cells first computes the copy offset, then streams
// one result per cycle from the source memory port unless the output stalls.
// After a copy count write, the next emit also recomputes the grid position by division.
// Synchronous active-low reset clears the set, copy index and registers, not the memory.
module voxel_set_grid_replicator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [vsgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vsgr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic                               in_first_cell,
  input  logic signed [vsgr_pkg::CELL_W-1:0] in_cell_x,
  input  logic signed [vsgr_pkg::CELL_W-1:0] in_cell_y,
  input  logic signed [vsgr_pkg::CELL_W-1:0] in_cell_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vsgr_pkg::OUT_W-1:0]  out_x,
  output logic signed [vsgr_pkg::OUT_W-1:0]  out_y,
  output logic signed [vsgr_pkg::OUT_W-1:0]  out_z,
  output logic                               out_copy_end,
  output logic                               out_array_end
);
  import vsgr_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_OFS, T_STREAM} state_t;

  state_t             state_r;
  cfg_t               cfg_r;
  logic [CNT_W-1:0]   count_r;
  logic [CI_W-1:0]    copy_index_r;
  cnt_t [2:0]         idx_r;
  logic               idx_ok_r;
  coord_t [2:0]       box_min_r;
  coord_t [2:0]       box_max_r;
  logic [CNT_W-1:0]   rd_addr_r;
  logic               q_v_r;
  logic               q_last_r;
  logic [MEM_W-1:0]   mem_q_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_x_r;
  logic [OUT_W-1:0]   out_y_r;
  logic [OUT_W-1:0]   out_z_r;
  logic               out_copy_end_r;
  logic               out_array_end_r;

  logic [MEM_W-1:0]   mem [SRC_DEPTH];

  ofs_req_t           req;
  ofs_rsp_t           rsp;
  logic               in_acc;
  logic               load_acc;
  logic               load_wr;
  logic [CNT_W-1:0]   eff_count;
  coord_t [2:0]       ld_cell;
  logic               out_load;
  logic               rd_en;
  coord_t [2:0]       q_cell;

  // Next grid position in x-outer, z-inner order.
  function automatic logic [3*CNT_BITS-1:0] idx_next(input cnt_t [2:0] idx,
                                                     input logic [CI_W-1:0] counts);
    cnt_t [2:0] n;
    cnt_t [2:0] c;
    for (int a = 0; a < 3; a++) begin
      c[a] = clamp_cnt(counts[CNT_BITS*a +: CNT_BITS]);
    end
    n = idx;
    if (idx[2] != c[2] - cnt_t'(1)) begin
      n[2] = idx[2] + cnt_t'(1);
    end else begin
      n[2] = '0;
      if (idx[1] != c[1] - cnt_t'(1)) begin
        n[1] = idx[1] + cnt_t'(1);
      end else begin
        n[1] = '0;
        n[0] = (idx[0] != c[0] - cnt_t'(1)) ? idx[0] + cnt_t'(1) : '0;
      end
    end
    return n;
  endfunction

  assign in_ready   = (state_r == T_IDLE);
  assign in_acc     = in_valid & in_ready;
  assign load_acc   = in_acc & (in_cmd == CMD_LOAD);
  assign eff_count  = in_first_cell ? '0 : count_r;
  assign load_wr    = load_acc & (eff_count < CNT_W'(SRC_DEPTH));
  assign ld_cell[0] = to_coord(in_cell_x);
  assign ld_cell[1] = to_coord(in_cell_y);
  assign ld_cell[2] = to_coord(in_cell_z);

  assign req.start  = in_acc & (in_cmd == CMD_EMIT) & (count_r != '0);
  assign req.ci     = copy_index_r;
  assign req.idx_ok = idx_ok_r;
  assign req.idx    = idx_r;

  // The read data stage holds one cell; a read is issued only when that stage has room.
  assign out_load = q_v_r & (~out_valid_r | out_ready);
  assign rd_en    = (state_r == T_STREAM) & (rd_addr_r < count_r) & (~q_v_r | out_load);

  assign q_cell[0] = mem_q_r[COORD_BITS-1:0];
  assign q_cell[1] = mem_q_r[2*COORD_BITS-1:COORD_BITS];
  assign q_cell[2] = mem_q_r[3*COORD_BITS-1:2*COORD_BITS];

  vsgr_offset u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .box_min (box_min_r),
    .box_max (box_max_r),
    .req     (req),
    .rsp     (rsp)
  );

  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[eff_count[ADDR_W-1:0]] <= {ld_cell[2], ld_cell[1], ld_cell[0]};
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      count_r       <= '0;
      copy_index_r  <= '0;
      idx_r         <= '0;
      idx_ok_r      <= 1'b1;
      rd_addr_r     <= '0;
      q_v_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      cfg_r.counts  <= COUNTS_RESET;
      cfg_r.rel     <= {3{REL_RESET}};
      cfg_r.add     <= '0;
      cfg_r.center  <= 1'b0;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (load_acc) begin
            if (in_first_cell) begin
              copy_index_r <= '0;
              idx_r        <= '0;
              idx_ok_r     <= 1'b1;
            end
            count_r <= load_wr ? eff_count + CNT_W'(1) : eff_count;
            if (load_wr) begin
              for (int a = 0; a < 3; a++) begin
                if (eff_count == '0 || $signed(ld_cell[a]) < $signed(box_min_r[a])) begin
                  box_min_r[a] <= ld_cell[a];
                end
                if (eff_count == '0 || $signed(ld_cell[a]) > $signed(box_max_r[a])) begin
                  box_max_r[a] <= ld_cell[a];
                end
              end
            end
          end else if (req.start) begin
            state_r <= T_OFS;
          end
        end
        T_OFS: begin
          if (rsp.done) begin
            copy_index_r <= rsp.last ? '0 : rsp.ci + CI_W'(1);
            idx_r        <= idx_next(rsp.idx, cfg_r.counts);
            idx_ok_r     <= 1'b1;
            rd_addr_r    <= '0;
            state_r      <= T_STREAM;
          end
        end
        T_STREAM: begin
          if (rd_en) begin
            rd_addr_r <= rd_addr_r + CNT_W'(1);
          end
          if (rd_addr_r == count_r && !q_v_r) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase

      q_v_r <= rd_en | (q_v_r & ~out_load);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Rewritten counts invalidate the cached grid position.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COPY_COUNTS: begin
            cfg_r.counts <= cfg_data[CI_W-1:0];
            idx_ok_r     <= 1'b0;
          end
          REG_REL_STEP_X: cfg_r.rel[0] <= cfg_data[REL_W-1:0];
          REG_REL_STEP_Y: cfg_r.rel[1] <= cfg_data[REL_W-1:0];
          REG_REL_STEP_Z: cfg_r.rel[2] <= cfg_data[REL_W-1:0];
          REG_ADD_STEP_X: cfg_r.add[0] <= cfg_data[ADD_W-1:0];
          REG_ADD_STEP_Y: cfg_r.add[1] <= cfg_data[ADD_W-1:0];
          REG_ADD_STEP_Z: cfg_r.add[2] <= cfg_data[ADD_W-1:0];
          REG_CENTER_EN:  cfg_r.center <= cfg_data[0];
          default: ;
        endcase
      end
    end

    if (rd_en) begin
      q_last_r <= (rd_addr_r == count_r - CNT_W'(1));
    end
    if (out_load) begin
      out_x_r         <= OUT_W'($signed(q_cell[0])) + rsp.off[0];
      out_y_r         <= OUT_W'($signed(q_cell[1])) + rsp.off[1];
      out_z_r         <= OUT_W'($signed(q_cell[2])) + rsp.off[2];
      out_copy_end_r  <= q_last_r;
      out_array_end_r <= rsp.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_copy_end  = out_copy_end_r;
  assign out_array_end = out_array_end_r;

`ifndef SYNTH
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_IDLE) |-> !q_v_r)
    else $error("read data still pending while the block takes requests");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SRC_DEPTH))
    else $error("source count beyond store depth");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == T_OFS))
    else $error("offset unit finished while no emit request was waiting");

  a_stream_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_STREAM) |-> (count_r != '0))
    else $error("copy streamed from an empty set");
`endif

endmodule

>>> rtl/vsgr_offset.sv
// Per-copy offset unit: grid position, step, centering shift and copy offset.
module vsgr_offset (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vsgr_pkg::cfg_t         cfg,
  input  vsgr_pkg::coord_t [2:0] box_min,
  input  vsgr_pkg::coord_t [2:0] box_max,
  input  vsgr_pkg::ofs_req_t     req,
  output vsgr_pkg::ofs_rsp_t     rsp
);
  import vsgr_pkg::*;

  localparam int EXT_W  = COORD_BITS + 2;
  localparam int PW     = COORD_BITS + 16;
  localparam int STEP_W = COORD_BITS + 10;
  localparam int SH_W   = STEP_W + 6;
  localparam int PXY_W  = 2 * CNT_BITS;
  localparam int DIV_CW = $clog2(CI_W);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(CI_W - 1);
  localparam logic signed [PW:0] RND_HALF = 128;

  typedef enum logic [3:0] {
    S_IDLE, S_TOT, S_TOT2, S_CHK, S_DIVZ, S_DIVY, S_MUL, S_STEP, S_MUL2, S_OFF
  } state_t;

  state_t                   state_r;
  logic                     done_r;
  logic                     last_r;
  logic [CI_W-1:0]          ci_r;
  cnt_t [2:0]               idx_r;
  logic [PXY_W-1:0]         pxy_r;
  logic [CI_W-1:0]          total_r;
  logic [CI_W-1:0]          quo_r;
  cnt_t                     rem_r;
  cnt_t                     den_r;
  logic [DIV_CW-1:0]        bit_r;
  logic signed [EXT_W-1:0]  ext_r  [3];
  logic signed [PW-1:0]     prod_r [3];
  logic signed [STEP_W-1:0] step_r [3];
  logic signed [SH_W-1:0]   sh_r   [3];
  logic signed [SH_W-1:0]   ip_r   [3];
  logic [2:0][OUT_W-1:0]    off_r;

  cnt_t                     cnt [3];
  logic [CNT_BITS:0]        trial;
  logic [CNT_BITS:0]        diff;
  logic                     ge;
  cnt_t                     div_rem_nxt;
  logic [CI_W-1:0]          div_quo_nxt;
  logic [CI_W-1:0]          ci_chk;
  logic signed [PW:0]       rnd  [3];
  logic signed [STEP_W-1:0] step [3];
  logic signed [SH_W-1:0]   half [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cnt[a]  = clamp_cnt(cfg.counts[CNT_BITS*a +: CNT_BITS]);
      rnd[a]  = (PW+1)'(prod_r[a]) + RND_HALF;
      step[a] = STEP_W'($signed(rnd[a][PW:8])) + STEP_W'($signed(cfg.add[a]));
      // Halving truncates toward zero, so negative values are rounded up first.
      half[a] = sh_r[a][SH_W-1] ? ((sh_r[a] + $signed(SH_W'(1))) >>> 1) : (sh_r[a] >>> 1);
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    trial       = {rem_r, quo_r[CI_W-1]};
    ge          = trial >= {1'b0, den_r};
    diff        = trial - {1'b0, den_r};
    div_rem_nxt = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    div_quo_nxt = {quo_r[CI_W-2:0], ge};
    ci_chk      = (ci_r < total_r) ? ci_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            ci_r  <= req.ci;
            idx_r <= req.idx;
            for (int a = 0; a < 3; a++) begin
              ext_r[a] <= EXT_W'($signed(box_max[a])) - EXT_W'($signed(box_min[a]))
                          + $signed(EXT_W'(1));
            end
            state_r <= req.idx_ok ? S_MUL : S_TOT;
          end
        end
        S_TOT: begin
          pxy_r   <= PXY_W'(cnt[0]) * PXY_W'(cnt[1]);
          state_r <= S_TOT2;
        end
        S_TOT2: begin
          total_r <= CI_W'(pxy_r) * CI_W'(cnt[2]);
          state_r <= S_CHK;
        end
        S_CHK: begin
          // A copy index left out of range by a count change restarts at copy 0.
          ci_r    <= ci_chk;
          quo_r   <= ci_chk;
          rem_r   <= '0;
          den_r   <= cnt[2];
          bit_r   <= DIV_LAST;
          state_r <= S_DIVZ;
        end
        S_DIVZ: begin
          if (bit_r == '0) begin
            idx_r[2] <= div_rem_nxt;
            quo_r    <= div_quo_nxt;
            rem_r    <= '0;
            den_r    <= cnt[1];
            bit_r    <= DIV_LAST;
            state_r  <= S_DIVY;
          end else begin
            quo_r <= div_quo_nxt;
            rem_r <= div_rem_nxt;
            bit_r <= bit_r - DIV_CW'(1);
          end
        end
        S_DIVY: begin
          if (bit_r == '0) begin
            idx_r[1] <= div_rem_nxt;
            idx_r[0] <= div_quo_nxt[CNT_BITS-1:0];
            state_r  <= S_MUL;
          end else begin
            quo_r <= div_quo_nxt;
            rem_r <= div_rem_nxt;
            bit_r <= bit_r - DIV_CW'(1);
          end
        end
        S_MUL: begin
          for (int a = 0; a < 3; a++) begin
            prod_r[a] <= PW'(ext_r[a]) * PW'($signed(cfg.rel[a]));
          end
          state_r <= S_STEP;
        end
        S_STEP: begin
          for (int a = 0; a < 3; a++) begin
            step_r[a] <= step[a];
          end
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          for (int a = 0; a < 3; a++) begin
            sh_r[a] <= SH_W'(step_r[a]) * SH_W'($signed({1'b0, cnt[a] - cnt_t'(1)}));
            ip_r[a] <= SH_W'(step_r[a]) * SH_W'($signed({1'b0, idx_r[a]}));
          end
          state_r <= S_OFF;
        end
        S_OFF: begin
          for (int a = 0; a < 3; a++) begin
            off_r[a] <= cfg.center ? OUT_W'(ip_r[a] - half[a]) : OUT_W'(ip_r[a]);
          end
          last_r  <= (idx_r[0] == cnt[0] - cnt_t'(1)) && (idx_r[1] == cnt[1] - cnt_t'(1))
                     && (idx_r[2] == cnt[2] - cnt_t'(1));
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.last = last_r;
  assign rsp.ci   = ci_r;
  assign rsp.idx  = idx_r;
  assign rsp.off  = off_r;

endmodule

>>> dv/vsgr_copy_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every translated cell of the replicator and compares the result stream.
module vsgr_copy_checker
  import vsgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_cmd,
  input  logic                  in_first_cell,
  input  logic [CELL_W-1:0]     in_cell_x,
  input  logic [CELL_W-1:0]     in_cell_y,
  input  logic [CELL_W-1:0]     in_cell_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_W-1:0]      out_x,
  input  logic [OUT_W-1:0]      out_y,
  input  logic [OUT_W-1:0]      out_z,
  input  logic                  out_copy_end,
  input  logic                  out_array_end,
  output int                    mismatches,
  output int                    expected_left
);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             copy_end;
    logic             array_end;
  } cell_out_t;

  cell_out_t       pending_cells[$];
  coord_t          set_cells[SRC_DEPTH][3];
  int              set_size;
  longint          box_lo[3];
  longint          box_hi[3];
  longint          grid_pos;
  logic [CI_W-1:0] copy_counts;
  rel_t            rel_step[3];
  add_t            add_step[3];
  logic            center_on;
  int              failures;

  function automatic void clear_model();
    int a;
    set_size    = 0;
    grid_pos    = 0;
    copy_counts = COUNTS_RESET;
    center_on   = 1'b0;
    for (a = 0; a < 3; a++) begin
      rel_step[a] = REL_RESET;
      add_step[a] = '0;
      box_lo[a]   = 0;
      box_hi[a]   = 0;
    end
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COPY_COUNTS: copy_counts = data[CI_W-1:0];
      REG_REL_STEP_X:  rel_step[0] = data[REL_W-1:0];
      REG_REL_STEP_Y:  rel_step[1] = data[REL_W-1:0];
      REG_REL_STEP_Z:  rel_step[2] = data[REL_W-1:0];
      REG_ADD_STEP_X:  add_step[0] = data;
      REG_ADD_STEP_Y:  add_step[1] = data;
      REG_ADD_STEP_Z:  add_step[2] = data;
      REG_CENTER_EN:   center_on   = data[0];
      default: ;
    endcase
  endfunction

  function automatic void store_cell(input logic first, input coord_t cx, input coord_t cy,
                                     input coord_t cz);
    coord_t c[3];
    int     a;
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    if (first) begin
      set_size = 0;
      grid_pos = 0;
    end
    // A full store drops the cell and leaves the box alone.
    if (set_size >= SRC_DEPTH) return;
    for (a = 0; a < 3; a++) begin
      set_cells[set_size][a] = c[a];
      if (set_size == 0 || c[a] < box_lo[a]) box_lo[a] = c[a];
      if (set_size == 0 || c[a] > box_hi[a]) box_hi[a] = c[a];
    end
    set_size++;
  endfunction

  function automatic void replicate_set();
    longint    n[3];
    longint    stp[3];
    longint    sh[3];
    longint    ofs[3];
    longint    ix[3];
    longint    ext;
    longint    total;
    longint    ci;
    logic      last;
    cell_out_t r;
    int        a;
    int        k;
    if (set_size == 0) return;
    for (a = 0; a < 3; a++) begin
      n[a] = longint'(copy_counts[CNT_BITS*a +: CNT_BITS]);
      if (n[a] == 0) n[a] = 1;
      ext = box_hi[a] - box_lo[a] + 1;
      // The arithmetic shift floors, so adding half first rounds halves upward.
      stp[a] = ((ext * longint'(rel_step[a]) + 128) >>> 8) + longint'(add_step[a]);
      // Integer division truncates toward zero, as the centering shift requires.
      sh[a] = center_on ? -(((n[a] - 1) * stp[a]) / 2) : 0;
    end
    total = n[0] * n[1] * n[2];
    // A position left over from larger counts restarts the grid.
    ci = (grid_pos < total) ? grid_pos : 0;
    ix[2] = ci % n[2];
    ix[1] = (ci / n[2]) % n[1];
    ix[0] = ci / (n[2] * n[1]);
    for (a = 0; a < 3; a++) ofs[a] = ix[a] * stp[a] + sh[a];
    last = (ci + 1 == total);
    grid_pos = last ? 0 : ci + 1;
    for (k = 0; k < set_size; k++) begin
      r.x         = OUT_W'(longint'(set_cells[k][0]) + ofs[0]);
      r.y         = OUT_W'(longint'(set_cells[k][1]) + ofs[1]);
      r.z         = OUT_W'(longint'(set_cells[k][2]) + ofs[2]);
      r.copy_end  = (k == set_size - 1);
      r.array_end = last;
      pending_cells.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    cell_out_t want;
    cell_out_t got;
    if (!rst_n) begin
      clear_model();
      pending_cells.delete();
    end else begin
      if (cfg_wr_en) write_register(cfg_index, cfg_data);
      // Results are handled before the request of the same edge; none can be that quick.
      if (out_valid && out_ready) begin
        got = {out_x, out_y, out_z, out_copy_end, out_array_end};
        if (pending_cells.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("ERROR at %0t: unexpected cell x=%0d y=%0d z=%0d copy_end=%0b array_end=%0b",
                     $time, $signed(got.x), $signed(got.y), $signed(got.z), got.copy_end,
                     got.array_end);
        end else begin
          want = pending_cells.pop_front();
          if (got.x != want.x || got.y != want.y || got.z != want.z ||
              got.copy_end != want.copy_end || got.array_end != want.array_end) begin
            failures++;
            if (failures <= 10)
              $display("ERROR at %0t: expected x=%0d y=%0d z=%0d copy_end=%0b array_end=%0b, %s",
                       $time, $signed(want.x), $signed(want.y), $signed(want.z),
                       want.copy_end, want.array_end,
                       $sformatf("got x=%0d y=%0d z=%0d copy_end=%0b array_end=%0b",
                                 $signed(got.x), $signed(got.y), $signed(got.z),
                                 got.copy_end, got.array_end));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_LOAD) begin
          store_cell(in_first_cell, in_cell_x[COORD_BITS-1:0], in_cell_y[COORD_BITS-1:0],
                     in_cell_z[COORD_BITS-1:0]);
        end else begin
          replicate_set();
        end
      end
    end
    mismatches    <= failures;
    expected_left <= pending_cells.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the replicator testbench: clock, reset, register programming and request traffic.
module testbench;
  import vsgr_pkg::*;

  typedef enum int {CFG_RANDOM, CFG_LOW_EXTREME, CFG_HIGH_EXTREME} cfg_style_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [CFG_DATA_W-1:0]    cfg_data      = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic                     in_cmd        = CMD_LOAD;
  logic                     in_first_cell = 1'b0;
  logic signed [CELL_W-1:0] in_cell_x     = '0;
  logic signed [CELL_W-1:0] in_cell_y     = '0;
  logic signed [CELL_W-1:0] in_cell_z     = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [OUT_W-1:0]  out_x;
  logic signed [OUT_W-1:0]  out_y;
  logic signed [OUT_W-1:0]  out_z;
  logic                     out_copy_end;
  logic                     out_array_end;
  int                       mismatches;
  int                       expected_left;
  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  logic [CFG_DATA_W-1:0]    cfg_plan[1 << CFG_IDX_W];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_set_grid_replicator_unit uut (.*);

  vsgr_copy_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_request(input logic cmd, input logic first, input logic [CELL_W-1:0] x,
                              input logic [CELL_W-1:0] y, input logic [CELL_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_first_cell <= first;
    in_cell_x     <= x;
    in_cell_y     <= y;
    in_cell_z     <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Every register is rewritten each time, register i at index i.
  task automatic program_registers();
    int i;
    for (i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= cfg_plan[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Registers may only change once the last copy is out and the block has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_counts();
    logic [CFG_DATA_W-1:0] c;
    int                    a;
    c = CFG_DATA_W'($urandom);
    for (a = 0; a < 3; a++)
      c[CNT_BITS*a +: CNT_BITS] = ($urandom_range(4) == 0) ? CNT_BITS'($urandom_range(31))
                                                          : CNT_BITS'($urandom_range(3));
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_rel();
    logic [CFG_DATA_W-1:0] d;
    logic [REL_W-1:0]      v;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(6))
      0:       v = {1'b1, {(REL_W-1){1'b0}}};
      1:       v = {1'b0, {(REL_W-1){1'b1}}};
      2:       v = '0;
      3:       v = REL_RESET;
      4:       v = REL_W'(-128);
      default: v = REL_W'($urandom);
    endcase
    d[REL_W-1:0] = v;
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_add();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return CFG_DATA_W'($urandom_range(16)) - CFG_DATA_W'(8);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic pick_config(input cfg_style_t style);
    case (style)
      CFG_LOW_EXTREME: begin
        cfg_plan[REG_COPY_COUNTS] = '1;
        cfg_plan[REG_REL_STEP_X]  = 16'h2000;
        cfg_plan[REG_REL_STEP_Y]  = 16'h2000;
        cfg_plan[REG_REL_STEP_Z]  = 16'h2000;
        cfg_plan[REG_ADD_STEP_X]  = 16'h8000;
        cfg_plan[REG_ADD_STEP_Y]  = 16'h8000;
        cfg_plan[REG_ADD_STEP_Z]  = 16'h8000;
        cfg_plan[REG_CENTER_EN]   = 16'h0001;
      end
      CFG_HIGH_EXTREME: begin
        cfg_plan[REG_COPY_COUNTS] = '0;
        cfg_plan[REG_REL_STEP_X]  = 16'h1fff;
        cfg_plan[REG_REL_STEP_Y]  = 16'h1fff;
        cfg_plan[REG_REL_STEP_Z]  = 16'h1fff;
        cfg_plan[REG_ADD_STEP_X]  = 16'h7fff;
        cfg_plan[REG_ADD_STEP_Y]  = 16'h7fff;
        cfg_plan[REG_ADD_STEP_Z]  = 16'h7fff;
        cfg_plan[REG_CENTER_EN]   = 16'h0000;
      end
      default: begin
        cfg_plan[REG_COPY_COUNTS] = rand_counts();
        cfg_plan[REG_REL_STEP_X]  = rand_rel();
        cfg_plan[REG_REL_STEP_Y]  = rand_rel();
        cfg_plan[REG_REL_STEP_Z]  = rand_rel();
        cfg_plan[REG_ADD_STEP_X]  = rand_add();
        cfg_plan[REG_ADD_STEP_Y]  = rand_add();
        cfg_plan[REG_ADD_STEP_Z]  = rand_add();
        cfg_plan[REG_CENTER_EN]   = CFG_DATA_W'($urandom);
      end
    endcase
  endtask

  // Mode 0 spreads cells over the whole range, mode 3 sits on the extremes,
  // the others keep a tight cluster so the box extent stays small.
  function automatic logic [CELL_W-1:0] set_coord(input int mode, input logic [CELL_W-1:0] base);
    case (mode)
      0:       return CELL_W'($urandom);
      3:       return ($urandom_range(1) == 0) ? 16'h8000 : 16'h7fff;
      default: return base + CELL_W'($urandom_range(15));
    endcase
  endfunction

  // Mostly a fresh set followed by a burst of emit requests; some bursts continue
  // the current set, and a few requests are pure noise.
  task automatic run_traffic(input int n_items);
    int                sent;
    int                kind;
    int                size;
    int                mode;
    int                bursts;
    int                i;
    logic [CELL_W-1:0] bx;
    logic [CELL_W-1:0] by;
    logic [CELL_W-1:0] bz;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      bursts = 0;
      if (kind < 65) begin
        kind = $urandom_range(99);
        size = (kind < 85) ? $urandom_range(1, 8) :
               (kind < 95) ? $urandom_range(9, 40) : $urandom_range(60, 70);
        mode = $urandom_range(3);
        bx = CELL_W'($urandom);
        by = CELL_W'($urandom);
        bz = CELL_W'($urandom);
        for (i = 0; i < size; i++) begin
          send_request(CMD_LOAD, i == 0, set_coord(mode, bx), set_coord(mode, by),
                       set_coord(mode, bz));
          if (i < SRC_DEPTH) sent++;
        end
        bursts = $urandom_range(1, 8);
      end else if (kind < 85) begin
        bursts = $urandom_range(1, 4);
      end else begin
        size = $urandom_range(1, 6);
        for (i = 0; i < size; i++) begin
          send_request(1'($urandom_range(1)), $urandom_range(3) == 0, CELL_W'($urandom),
                       CELL_W'($urandom), CELL_W'($urandom));
          sent++;
        end
      end
      for (i = 0; i < bursts; i++) begin
        send_request(CMD_EMIT, 1'($urandom_range(1)), CELL_W'($urandom), CELL_W'($urandom),
                     CELL_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int phase;
    int blk;
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: an emit on the empty set gives nothing, then a single copy each time.
    send_request(CMD_EMIT, 1'b0, '0, '0, '0);
    send_request(CMD_LOAD, 1'b1, 16'h8000, 16'h7fff, 16'h0000);
    send_request(CMD_LOAD, 1'b0, 16'h7fff, 16'h8000, 16'hffff);
    send_request(CMD_LOAD, 1'b0, 16'h0001, 16'hffff, 16'h5555);
    repeat (2) send_request(CMD_EMIT, 1'b1, '1, '1, '1);

    // A 2x1x3 grid with centering; the odd z extent hits the half-way rounding.
    wait_idle();
    cfg_plan[REG_COPY_COUNTS] = {1'b0, 5'd3, 5'd1, 5'd2};
    cfg_plan[REG_REL_STEP_X]  = 16'h1fff;
    cfg_plan[REG_REL_STEP_Y]  = 16'h3f80;
    cfg_plan[REG_REL_STEP_Z]  = 16'h0080;
    cfg_plan[REG_ADD_STEP_X]  = 16'h7fff;
    cfg_plan[REG_ADD_STEP_Y]  = 16'h8000;
    cfg_plan[REG_ADD_STEP_Z]  = 16'h0001;
    cfg_plan[REG_CENTER_EN]   = 16'h0001;
    program_registers();
    repeat (8) send_request(CMD_EMIT, 1'b0, '0, '0, '0);

    // Shrinking the grid leaves the copy position out of range, so the next copy restarts.
    wait_idle();
    cfg_plan[REG_COPY_COUNTS] = {1'b0, 5'd2, 5'd0, 5'd0};
    cfg_plan[REG_CENTER_EN]   = 16'h0000;
    program_registers();
    repeat (2) send_request(CMD_EMIT, 1'b0, '0, '0, '0);
    send_request(CMD_LOAD, 1'b1, 16'h0010, 16'h0020, 16'h0030);
    repeat (2) send_request(CMD_EMIT, 1'b0, '0, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (blk = 0; blk < 2; blk++) begin
        wait_idle();
        if (phase == 0 && blk == 1) pick_config(CFG_LOW_EXTREME);
        else if (phase == 2 && blk == 1) pick_config(CFG_HIGH_EXTREME);
        else pick_config(CFG_RANDOM);
        program_registers();
        if (phase == 0 && blk == 0) begin
          // Fill past the store depth once; the extra cells must be dropped.
          for (i = 0; i < SRC_DEPTH + 2; i++)
            send_request(CMD_LOAD, i == 0, CELL_W'($urandom), CELL_W'($urandom),
                         CELL_W'($urandom));
          send_request(CMD_EMIT, 1'b0, '0, '0, '0);
        end
        run_traffic(40);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
